/* hw/rtl/dm2_pkg.sv */
// ----------------------------------------------------------------------------
// Diamond2 package
// Shared constants and a CRC table function for the Diamond2 block cipher unit.
// ----------------------------------------------------------------------------
package dm2_pkg;

  localparam logic [1:0] MODE_KEY = 2'd0;
  localparam logic [1:0] MODE_ENC = 2'd1;
  localparam logic [1:0] MODE_DEC = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ROUND = 2'd1;
  localparam logic [1:0] ST_BAD_BLOCK = 2'd2;
  localparam logic [1:0] ST_UNKEYED   = 2'd3;

  localparam logic [2:0] REG_KEY_LOW  = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH = 3'd1;
  localparam logic [2:0] REG_KEY_LEN  = 3'd2;
  localparam logic [2:0] REG_ROUNDS   = 3'd3;
  localparam logic [2:0] REG_BLOCK    = 3'd4;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam int DRAW_TRIES = 97;

  function automatic logic [31:0] crc_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/diamond2_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// Diamond2 block cipher unit
// Key schedule into box memories, then encrypt and decrypt of 8 or 16 byte
// blocks.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result appears
// for a single cycle with done high and cannot be held off. Encrypt and
// decrypt read each byte lane of each round through the single read port of
// the box memory in the states S_ERD, S_EWAIT and S_ESTORE, with a bit permute
// in S_PERM between rounds, and the result is registered in S_PERM after the
// last round. A key set builds every box one entry at a time: each draw feeds
// one or more bytes through the CRC and each placement walks the free-slot
// marks one step a cycle. Once every box is built, the inverse boxes are written
// in a second sweep through S_INVRD, S_INVWR, S_EWAIT and S_ESTORE per entry.
module diamond2_block_cipher_unit #(
  parameter int MAX_BOXES = 256,
  parameter int KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [1:0]  mode,
  input  logic [63:0] data_low,
  input  logic [63:0] data_high,
  output logic [63:0] result_low,
  output logic [63:0] result_high,
  output logic [1:0]  status
);
  import dm2_pkg::*;

  localparam int AW = $clog2(MAX_BOXES) + 8;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_BOXINI = 13'b0000000000010,
    S_FEED   = 13'b0000000000100,
    S_CHECK  = 13'b0000000001000,
    S_SEEK   = 13'b0000000010000,
    S_PLACE  = 13'b0000000100000,
    S_INVRD  = 13'b0000001000000,
    S_INVWR  = 13'b0000010000000,
    S_ERD    = 13'b0000100000000,
    S_EWAIT  = 13'b0001000000000,
    S_ESTORE = 13'b0010000000000,
    S_PERM   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state;

  logic [63:0] key_low, key_high;
  logic [4:0]  key_length, block_bytes;
  logic [7:0]  round_count;

  logic [7:0] fwd_mem [1 << AW];
  logic [7:0] inv_mem [1 << AW];
  logic [7:0] fwd_q, inv_q;
  logic       fwd_we, inv_we;
  logic [AW-1:0] fwd_wa, inv_wa, rd_a;
  logic [7:0] fwd_wd, inv_wd;

  logic [31:0] crc;
  logic [3:0]  key_pos;
  logic [255:0] taken;
  logic [7:0]  active_rounds;
  logic        active_block, keyed;

  logic [4:0]  klen;
  logic [8:0]  boxes;
  logic [8:0]  box;
  logic [8:0]  cur_n;
  logic [7:0]  mask;
  logic [6:0]  tries;
  logic [1:0]  feed_phase;
  logic [7:0]  pos, p;
  logic [8:0]  inv_k;
  logic [7:0]  blk [16];
  logic [7:0]  tmp [16];
  logic [3:0]  lane;
  logic [7:0]  rnd;
  logic        dec;
  logic [63:0] res_lo, res_hi;
  logic [1:0]  res_st;

  always_ff @(posedge clk) begin
    if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
    if (inv_we) inv_mem[inv_wa] <= inv_wd;
    fwd_q <= fwd_mem[rd_a];
    inv_q <= inv_mem[rd_a];
  end

  logic [7:0] kbyte, fbyte;
  logic [31:0] crc_fed;
  logic [4:0] nb;
  logic [7:0] draw_v;
  logic [AW-1:0] box_base;
  logic [8:0] rbox;

  always_comb begin
    kbyte = key_pos[3] ? key_high[8*key_pos[2:0] +: 8] : key_low[8*key_pos[2:0] +: 8];
    unique case (feed_phase)
      2'd0:    fbyte = kbyte;
      2'd1:    fbyte = {3'd0, klen};
      default: fbyte = 8'd0;
    endcase
    crc_fed = ((crc >> 8) & 32'h00FFFFFF) ^ crc_entry(crc[7:0] ^ fbyte);
    nb = active_block ? 5'd16 : 5'd8;
    draw_v = crc[7:0] & mask;
    if (tries >= 7'(DRAW_TRIES) && {1'b0, draw_v} > cur_n) begin
      draw_v = draw_v - cur_n[7:0];
    end
    rbox = 9'(dec ? (rnd - 8'd1) : rnd) * 9'(nb) + 9'(lane);
    box_base = AW'(rbox) << 8;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    fwd_we <= 1'b0;
    inv_we <= 1'b0;
    done   <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      key_low <= '0; key_high <= '0;
      key_length <= 5'd16; round_count <= 8'd3; block_bytes <= 5'd8;
      keyed <= 1'b0; active_rounds <= '0; active_block <= 1'b0;
      crc <= '1; key_pos <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_LOW:  key_low <= cfg_data;
          REG_KEY_HIGH: key_high <= cfg_data;
          REG_KEY_LEN:  key_length <= cfg_data[4:0];
          REG_ROUNDS:   round_count <= cfg_data[7:0];
          REG_BLOCK:    block_bytes <= cfg_data[4:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (start) begin
          res_lo <= '0; res_hi <= '0;
          if (mode == MODE_KEY) begin
            keyed <= 1'b0;
            if (block_bytes != 5'd8 && block_bytes != 5'd16) begin
              res_st <= ST_BAD_BLOCK; state <= S_DONE;
            end else if ((block_bytes == 5'd8 && round_count <= 8'd2) ||
                         (block_bytes == 5'd16 && round_count <= 8'd4) ||
                         (16'(round_count) * 16'(block_bytes) > 16'd255) ||
                         (16'(round_count) * 16'(block_bytes) > 16'(MAX_BOXES))) begin
              res_st <= ST_BAD_ROUND; state <= S_DONE;
            end else begin
              res_st <= ST_OK;
              boxes <= 9'(16'(round_count) * 16'(block_bytes));
              klen <= (key_length == 5'd0) ? 5'd1 :
                      (key_length > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : key_length;
              key_pos <= '0; crc <= '1; box <= '0;
              state <= S_BOXINI;
            end
          end else if (mode == MODE_ENC || mode == MODE_DEC) begin
            if (!keyed) begin
              res_st <= ST_UNKEYED; state <= S_DONE;
            end else begin
              res_st <= ST_OK;
              for (int i = 0; i < 8; i++) begin
                blk[i] <= data_low[8*i +: 8];
                blk[i+8] <= data_high[8*i +: 8];
              end
              dec <= (mode == MODE_DEC);
              rnd <= (mode == MODE_DEC) ? active_rounds : 8'd0;
              lane <= '0; state <= S_ERD;
            end
          end else begin
            res_st <= ST_OK;
            state <= S_DONE;
          end
        end
        S_BOXINI: begin
          taken <= '0; cur_n <= 9'd255; mask <= 8'hFF; tries <= '0;
          feed_phase <= 2'd0; state <= S_FEED;
        end
        S_FEED: begin
          crc <= crc_fed;
          if (feed_phase == 2'd0) begin
            if (5'(key_pos) + 5'd1 >= klen) begin
              key_pos <= '0; feed_phase <= 2'd1;
            end else begin
              key_pos <= key_pos + 4'd1; state <= S_CHECK;
            end
          end else if (feed_phase == 2'd1) begin
            feed_phase <= 2'd2;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          feed_phase <= 2'd0;
          if (tries != 7'h7F) tries <= tries + 7'd1;
          if ({1'b0, draw_v} > cur_n) begin
            state <= S_FEED;
          end else begin
            pos <= draw_v; p <= 8'd0; state <= S_SEEK;
          end
        end
        S_SEEK: begin
          if (p != 8'd255 && taken[p]) begin
            p <= p + 8'd1;
          end else if (pos != 8'd0) begin
            pos <= pos - 8'd1;
            if (p != 8'd255) p <= p + 8'd1;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          fwd_we <= 1'b1; fwd_wa <= AW'(box) << 8 | AW'(p); fwd_wd <= cur_n[7:0];
          taken[p] <= 1'b1;
          tries <= '0; feed_phase <= 2'd0;
          if (cur_n == 9'd0) begin
            if (box + 9'd1 == boxes) begin
              box <= '0; inv_k <= '0; state <= S_INVRD;
            end else begin
              box <= box + 9'd1; state <= S_BOXINI;
            end
          end else begin
            cur_n <= cur_n - 9'd1;
            mask <= ((cur_n - 9'd1) > 9'd127) ? 8'hFF : ((cur_n - 9'd1) > 9'd63) ? 8'h7F :
                    ((cur_n - 9'd1) > 9'd31) ? 8'h3F : ((cur_n - 9'd1) > 9'd15) ? 8'h1F :
                    ((cur_n - 9'd1) > 9'd7) ? 8'h0F : ((cur_n - 9'd1) > 9'd3) ? 8'h07 :
                    ((cur_n - 9'd1) > 9'd1) ? 8'h03 : 8'h01;
            if (cur_n == 9'd1) begin
              pos <= 8'd0; p <= 8'd0; state <= S_SEEK;
            end else begin
              state <= S_FEED;
            end
          end
        end
        S_INVRD: begin
          rd_a <= AW'(box) << 8 | AW'(inv_k[7:0]);
          state <= S_INVWR;
        end
        S_INVWR: begin
          state <= S_EWAIT;
        end
        S_EWAIT: begin
          state <= S_ESTORE;
        end
        S_ERD: begin
          rd_a <= box_base | AW'(blk[lane]);
          state <= S_EWAIT;
        end
        S_ESTORE: begin
          if (inv_k != 9'h100 && boxes != 9'd0 && !keyed) begin
            inv_we <= 1'b1; inv_wa <= AW'(box) << 8 | AW'(fwd_q); inv_wd <= inv_k[7:0];
            if (inv_k == 9'd255) begin
              inv_k <= '0;
              if (box + 9'd1 == boxes) begin
                active_rounds <= round_count; active_block <= (block_bytes == 5'd16);
                keyed <= 1'b1; boxes <= '0; state <= S_DONE;
              end else begin
                box <= box + 9'd1; state <= S_INVRD;
              end
            end else begin
              inv_k <= inv_k + 9'd1; state <= S_INVRD;
            end
          end else begin
            tmp[lane] <= dec ? inv_q : fwd_q;
            if (5'(lane) + 5'd1 == nb) begin
              lane <= '0; state <= S_PERM;
            end else begin
              lane <= lane + 4'd1; state <= S_ERD;
            end
          end
        end
        S_PERM: begin
          if ((!dec && rnd + 8'd1 >= active_rounds) || (dec && rnd <= 8'd1)) begin
            for (int i = 0; i < 8; i++) begin
              res_lo[8*i +: 8] <= tmp[i];
              res_hi[8*i +: 8] <= active_block ? tmp[i+8] : 8'd0;
            end
            state <= S_DONE;
          end else begin
            for (int i = 0; i < 16; i++) begin
              for (int j = 0; j < 8; j++) begin
                blk[i][j] <= dec ? tmp[4'(i + 16 - j) & 4'(nb - 5'd1)][j]
                                 : tmp[4'(i + j) & 4'(nb - 5'd1)][j];
              end
            end
            rnd <= dec ? rnd - 8'd1 : rnd + 8'd1;
            state <= S_ERD;
          end
        end
        S_DONE: begin
          done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_low  = res_lo;
  assign result_high = res_hi;
  assign status      = res_st;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_keyed_round: assert property (@(posedge clk) disable iff (rst)
    keyed |-> active_rounds >= 8'd3) else $error("keyed with too few rounds");
endmodule

/* test/diamond2_block_cipher_unit_test.sv */
// ----------------------------------------------------------------------------
// Diamond2 block cipher unit testbench
// Drives key-set, encrypt and decrypt items through the command port and
// compares every result with an in-bench cipher predictor that builds its
// own box tables. It covers error statuses, Lite and 16-byte blocks, then
// random traffic with random gaps.
// ----------------------------------------------------------------------------
module diamond2_block_cipher_unit_test;
  import dm2_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam longint unsigned CYCLE_LIMIT = 60_000_000;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [1:0]  st;
  } cipher_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy, done;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_KEY_LOW;
  logic [63:0] cfg_data = '0;
  logic [1:0]  mode = MODE_ENC;
  logic [63:0] data_low = '0;
  logic [63:0] data_high = '0;
  logic [63:0] result_low, result_high;
  logic [1:0]  status;

  // Shadow configuration and predicted cipher state.
  logic [63:0] key_low_reg = '0;
  logic [63:0] key_high_reg = '0;
  logic [4:0]  key_len_reg = 5'd16;
  logic [7:0]  rounds_reg = 8'd3;
  logic [4:0]  block_reg = 5'd8;
  logic [31:0] crc_table [256];
  logic [31:0] crc_state;
  int unsigned key_pos;
  logic [7:0]  fwd_box [65536];
  logic [7:0]  inv_box [65536];
  int unsigned live_rounds = 0;
  bit          live_wide = 1'b0;
  bit          keyed = 1'b0;

  cipher_result_t pending_results[$];
  cipher_result_t last_cipher;
  int unsigned errors = 0;
  longint unsigned cycles = 0;

  diamond2_block_cipher_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mode(mode), .data_low(data_low), .data_high(data_high),
    .result_low(result_low), .result_high(result_high), .status(status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    cipher_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result lo=%h hi=%h st=%0d", $time, result_low,
                 result_high, status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_low !== want.lo) begin
          $display("%0t: result_low expected %h actual %h", $time, want.lo, result_low);
          errors++;
        end
        if (result_high !== want.hi) begin
          $display("%0t: result_high expected %h actual %h", $time, want.hi, result_high);
          errors++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
      end
    end
  end

  function automatic void crc_push(logic [7:0] b);
    crc_state = ((crc_state >> 8) & 32'h00FFFFFF) ^ crc_table[crc_state[7:0] ^ b];
  endfunction

  function automatic logic [7:0] key_byte_at(int unsigned k);
    logic [127:0] key;
    key = {key_high_reg, key_low_reg};
    return key[8*(k & 15) +: 8];
  endfunction

  function automatic int unsigned draw_below(int unsigned limit, int unsigned len);
    int unsigned mask, t, tries, v;
    mask = 0;
    tries = 0;
    if (limit == 0) return 0;
    for (t = limit; t > 0; t = t >> 1) mask = (mask << 1) | 1;
    do begin
      crc_push(key_byte_at(key_pos));
      key_pos++;
      if (key_pos >= len) begin
        key_pos = 0;
        crc_push(len[7:0]);
        crc_push(len[15:8]);
      end
      v = crc_state & mask;
      tries++;
      if (tries > 97 && v > limit) v -= limit;
    end while (v > limit);
    return v;
  endfunction

  function automatic void build_one_box(int unsigned box, int unsigned len);
    bit taken [256];
    int unsigned pos, p, m;
    foreach (taken[i]) taken[i] = 1'b0;
    for (int n = 255; n >= 0; n--) begin
      pos = draw_below(n, len);
      p = 0;
      while (p < 255 && taken[p]) p++;
      for (m = 0; m < pos; m++) begin
        if (p < 255) p++;
        while (p < 255 && taken[p]) p++;
      end
      fwd_box[box*256 + p] = n[7:0];
      taken[p & 255] = 1'b1;
    end
  endfunction

  function automatic logic [1:0] schedule_keys();
    int unsigned bs, len, boxes;
    keyed = 1'b0;
    if (block_reg == 5'd8) bs = 8;
    else if (block_reg == 5'd16) bs = 16;
    else return ST_BAD_BLOCK;
    if ((bs == 8 && rounds_reg <= 2) || (bs == 16 && rounds_reg <= 4)) return ST_BAD_ROUND;
    boxes = rounds_reg * bs;
    if (boxes > 255) return ST_BAD_ROUND;
    len = (key_len_reg < 1) ? 1 : (key_len_reg > 16) ? 16 : key_len_reg;
    key_pos = 0;
    crc_state = 32'hFFFFFFFF;
    for (int unsigned b = 0; b < boxes; b++) build_one_box(b, len);
    for (int unsigned b = 0; b < boxes; b++)
      for (int k = 0; k < 256; k++) inv_box[b*256 + fwd_box[b*256 + k]] = k[7:0];
    live_rounds = rounds_reg;
    live_wide = (bs == 16);
    keyed = 1'b1;
    return ST_OK;
  endfunction

  function automatic cipher_result_t predict_cipher(logic [1:0] m, logic [63:0] lo,
                                                    logic [63:0] hi);
    cipher_result_t res;
    logic [7:0] a [16];
    logic [7:0] b [16];
    int unsigned n, r, src;
    res = '0;
    if (m == MODE_KEY) begin
      res.st = schedule_keys();
      return res;
    end
    if (m == MODE_NONE) return res;
    if (!keyed) begin
      res.st = ST_UNKEYED;
      return res;
    end
    n = live_wide ? 16 : 8;
    for (int i = 0; i < 16; i++) a[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    if (m == MODE_ENC) begin
      for (int i = 0; i < n; i++) b[i] = fwd_box[i*256 + a[i]];
      for (r = 1; r < live_rounds; r++) begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < 8; j++) begin
            src = (i + j) & (n - 1);
            a[i][j] = b[src][j];
          end
        for (int i = 0; i < n; i++) b[i] = fwd_box[(r*n + i)*256 + a[i]];
      end
    end else begin
      r = live_rounds;
      for (int i = 0; i < n; i++) b[i] = inv_box[((r-1)*n + i)*256 + a[i]];
      while (r >= 2) begin
        r--;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < 8; j++) begin
            src = (i + n - j) & (n - 1);
            a[i][j] = b[src][j];
          end
        for (int i = 0; i < n; i++) b[i] = inv_box[((r-1)*n + i)*256 + a[i]];
      end
    end
    for (int i = 0; i < n; i++)
      if (i < 8) res.lo[8*i +: 8] = b[i];
      else res.hi[8*(i-8) +: 8] = b[i];
    return res;
  endfunction

  task automatic send_item(logic [1:0] m, logic [63:0] lo, logic [63:0] hi);
    int unsigned gap, pick;
    @(negedge clk);
    start = 1'b1;
    mode = m;
    data_low = lo;
    data_high = hi;
    do @(posedge clk); while (busy);
    last_cipher = predict_cipher(m, lo, hi);
    pending_results.push_back(last_cipher);
    pick = $urandom_range(99);
    gap = (pick < 60) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_KEY_LOW:  key_low_reg = value;
      REG_KEY_HIGH: key_high_reg = value;
      REG_KEY_LEN:  key_len_reg = value[4:0];
      REG_ROUNDS:   rounds_reg = value[7:0];
      REG_BLOCK:    block_reg = value[4:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_unkeyed();
    send_item(MODE_ENC, '1, '1);
    send_item(MODE_DEC, '0, '0);
    send_item(MODE_NONE, '1, '0);
    settle();
  endtask

  task automatic test_bad_settings();
    write_reg(REG_BLOCK, 64'd0);
    send_item(MODE_KEY, '0, '0);
    write_reg(REG_BLOCK, 64'd31);
    send_item(MODE_KEY, '0, '0);
    write_reg(REG_BLOCK, 64'd12);
    send_item(MODE_KEY, '0, '0);
    write_reg(REG_BLOCK, 64'd8);
    write_reg(REG_ROUNDS, 64'd2);
    send_item(MODE_KEY, '0, '0);
    write_reg(REG_ROUNDS, 64'd0);
    send_item(MODE_KEY, '0, '0);
    write_reg(REG_ROUNDS, 64'd255);
    send_item(MODE_KEY, '0, '0);
    write_reg(REG_BLOCK, 64'd16);
    write_reg(REG_ROUNDS, 64'd4);
    send_item(MODE_KEY, '0, '0);
    write_reg(REG_ROUNDS, 64'd16);
    send_item(MODE_KEY, '0, '0);
    send_item(MODE_ENC, rand64(), rand64());
    settle();
  endtask

  task automatic run_traffic(int unsigned count);
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) send_item(MODE_ENC, rand64(), rand64());
      else if (pick < 80) send_item(MODE_DEC, rand64(), rand64());
      else if (pick < 95) send_item(MODE_DEC, last_cipher.lo, last_cipher.hi);
      else send_item(MODE_NONE, rand64(), rand64());
    end
  endtask

  task automatic test_lite_block();
    write_reg(REG_KEY_LOW, rand64());
    write_reg(REG_KEY_HIGH, rand64());
    write_reg(REG_KEY_LEN, 64'd0);
    write_reg(REG_ROUNDS, 64'd3);
    write_reg(REG_BLOCK, 64'd8);
    send_item(MODE_KEY, '0, '0);
    send_item(MODE_ENC, '0, '0);
    send_item(MODE_ENC, '1, '1);
    send_item(MODE_DEC, last_cipher.lo, '0);
    send_item(MODE_DEC, '1, '0);
    run_traffic(700);
    settle();
  endtask

  task automatic test_wide_block();
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, rand64());
    write_reg(REG_KEY_LEN, 64'd31);
    write_reg(REG_ROUNDS, 64'd5);
    write_reg(REG_BLOCK, 64'd16);
    send_item(MODE_KEY, '0, '0);
    send_item(MODE_ENC, '0, '1);
    send_item(MODE_ENC, '1, '0);
    send_item(MODE_DEC, last_cipher.lo, last_cipher.hi);
    run_traffic(700);
    settle();
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      logic [31:0] c;
      c = i;
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
      crc_table[i] = c;
    end
    last_cipher = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_unkeyed();
    test_bad_settings();
    test_lite_block();
    test_wide_block();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
